>>> sv/pss_pkg.sv
// Shared types and codes for the pitch step sequencer.
package pss_pkg;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] new_position;
        logic [3:0] entry_index;
        logic [7:0] entry_pitch;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pitch;
        logic [7:0] previous_pitch;
        logic [3:0] position;
    } t_out_item;

    // item functions
    localparam logic [1:0] FN_ADVANCE = 2'd0;
    localparam logic [1:0] FN_SET_POS = 2'd1;
    localparam logic [1:0] FN_WRITE   = 2'd2;
    localparam logic [1:0] FN_RESTART = 2'd3;

    // play orders
    localparam logic [1:0] ORD_FORWARD  = 2'd0;
    localparam logic [1:0] ORD_BACKWARD = 2'd1;
    localparam logic [1:0] ORD_PENDULUM = 2'd2;
    localparam logic [1:0] ORD_RANDOM   = 2'd3;

    // configuration register indexes
    localparam logic CFG_PLAY_ORDER = 1'b0;
    localparam logic CFG_SET_SIZE   = 1'b1;

    // generator constants
    localparam logic [31:0] LCG_MUL  = 32'd1103515245;
    localparam logic [31:0] LCG_INC  = 32'd12345;
    localparam logic [31:0] LCG_SEED = 32'h12345678;

endpackage

>>> sv/pitch_step_sequencer_core.sv
// Top level of the pitch step sequencer: sequencer, generator and table.
//
// Steps through the first set_size entries (at most MAX_PITCHES) of a
// pitch table in forward, backward, pendulum or random order, one item
// at a time. Write-entry, restart and empty-set items skip the remainder
// unit; advance and set position items that need a remainder run through
// a bit-serial modulo unit, one dividend bit per cycle, and the random
// order first runs the 32x32 generator multiply. The two table reads
// share one RAM read port and are made one after the other. o_in_stall
// is high while an item is in progress; a finished result waits in the
// output register, so the next item may enter before it is taken.
// Configuration is taken only while the block is idle; writing play_order
// resets the pendulum direction to upward and should be followed by a
// restart item.
module pitch_step_sequencer_core #(
    parameter int MAX_PITCHES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pss_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pss_pkg::t_out_item o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [4:0]        i_cfg_data
);

    import pss_pkg::*;

    localparam int PW  = $clog2(MAX_PITCHES);
    localparam int SZW = $clog2(MAX_PITCHES + 1);
    localparam int DVW = (PW + 1 > 8) ? PW + 1 : 8;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_LCG     = 4'd2;
    localparam logic [3:0] S_DSTART  = 4'd3;
    localparam logic [3:0] S_DIV     = 4'd4;
    localparam logic [3:0] S_RD_CUR  = 4'd5;
    localparam logic [3:0] S_RD_PREV = 4'd6;
    localparam logic [3:0] S_OUT     = 4'd7;

    logic [3:0]     r_state;
    t_in_item       r_item;
    logic [1:0]     r_order;
    logic [4:0]     r_set_size;
    logic [PW-1:0]  r_cur;
    logic [PW-1:0]  r_prev;
    logic           r_up;
    logic [31:0]    r_rand;
    logic [DVW-1:0] r_opnd;
    logic [7:0]     r_pitch;
    logic           r_out_valid;
    t_out_item      r_out;

    logic [SZW-1:0] w_used;
    logic           w_in_take;
    logic           w_cfg_take;
    logic           w_out_load;
    logic           w_is_rand;
    logic           w_turn_up;
    logic           w_mod_start;
    logic           w_mod_done;
    logic [SZW-1:0] w_mod_rem;
    logic [DVW-1:0] w_mod_dvd;
    logic           w_we;
    logic [PW-1:0]  w_raddr;
    logic [7:0]     w_rdata;

    assign w_used = (32'(r_set_size) > MAX_PITCHES) ? SZW'(MAX_PITCHES) : SZW'(r_set_size);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_in_take   = i_in_valid && (r_state == S_IDLE);
    assign w_cfg_take  = i_cfg_valid && (r_state == S_IDLE);
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign w_is_rand   = (r_item.func == FN_ADVANCE) && (r_order == ORD_RANDOM);

    // pendulum direction after the end-of-range check
    always_comb begin
        w_turn_up = r_up;
        if (r_up && (32'(r_cur) >= 32'(w_used) - 1)) begin
            w_turn_up = 1'b0;
        end else if (!r_up && (r_cur == '0)) begin
            w_turn_up = 1'b1;
        end
    end

    assign w_mod_start = (r_state == S_DSTART);
    assign w_mod_dvd   = w_is_rand ? DVW'(r_rand[23:16]) : r_opnd;

    pss_mod #(
        .DVW (DVW),
        .SZW (SZW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dvd),
        .i_divisor  (w_used),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    assign w_we    = (r_state == S_DECODE) && (r_item.func == FN_WRITE)
                     && (32'(r_item.entry_index) < MAX_PITCHES);
    assign w_raddr = (r_state == S_RD_CUR) ? r_cur : r_prev;

    pss_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PITCHES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (PW'(r_item.entry_index)),
        .i_wdata (r_item.entry_pitch),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_order     <= ORD_FORWARD;
            r_set_size  <= '0;
            r_cur       <= '0;
            r_prev      <= '0;
            r_up        <= 1'b1;
            r_rand      <= LCG_SEED;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_take) begin
                case (i_cfg_index)
                    CFG_PLAY_ORDER: begin
                        r_order <= i_cfg_data[1:0];
                        r_up    <= 1'b1;
                    end
                    CFG_SET_SIZE: r_set_size <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (r_item.func)
                        FN_ADVANCE: begin
                            if (w_used == SZW'(1)) begin
                                r_prev  <= r_cur;
                                r_cur   <= '0;
                                r_state <= S_RD_CUR;
                            end else if (w_used != '0) begin
                                r_prev <= r_cur;
                                case (r_order)
                                    ORD_FORWARD: begin
                                        r_state <= S_DSTART;
                                    end
                                    ORD_BACKWARD: begin
                                        r_state <= S_DSTART;
                                    end
                                    ORD_PENDULUM: begin
                                        r_up    <= w_turn_up;
                                        r_cur   <= w_turn_up ? r_cur + 1'b1 : r_cur - 1'b1;
                                        r_state <= S_RD_CUR;
                                    end
                                    default: begin
                                        r_state <= S_LCG;
                                    end
                                endcase
                            end else begin
                                r_state <= S_RD_CUR;
                            end
                        end
                        FN_SET_POS: begin
                            if (w_used == '0) begin
                                r_cur   <= '0;
                                r_prev  <= '0;
                                r_state <= S_RD_CUR;
                            end else begin
                                r_prev  <= r_cur;
                                r_state <= S_DSTART;
                            end
                        end
                        FN_WRITE: begin
                            r_state <= S_RD_CUR;
                        end
                        default: begin
                            r_cur   <= '0;
                            r_prev  <= '0;
                            r_up    <= 1'b1;
                            r_state <= S_RD_CUR;
                        end
                    endcase
                end
                S_LCG: begin
                    r_rand  <= r_rand * LCG_MUL + LCG_INC;
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_mod_done) begin
                        r_cur   <= PW'(w_mod_rem);
                        r_state <= S_RD_CUR;
                    end
                end
                S_RD_CUR: begin
                    r_state <= S_RD_PREV;
                end
                S_RD_PREV: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item <= i_in_data;
        end
        if (r_state == S_DECODE) begin
            if (r_item.func == FN_SET_POS) begin
                r_opnd <= DVW'(r_item.new_position);
            end else begin
                case (r_order)
                    ORD_BACKWARD: r_opnd <= DVW'(r_cur) + DVW'(w_used) - 1'b1;
                    default:      r_opnd <= DVW'(r_cur) + 1'b1;
                endcase
            end
        end
        // read data for the current position lands here
        if (r_state == S_RD_PREV) begin
            r_pitch <= w_rdata;
        end
        if (w_out_load) begin
            r_out.pitch          <= (w_used == '0) ? 8'd0 : r_pitch;
            r_out.previous_pitch <= (w_used == '0) ? 8'd0 : w_rdata;
            r_out.position       <= 4'(r_cur);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/pss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/pss_mod.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module pss_mod #(
    parameter int DVW = 9,
    parameter int SZW = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DVW-1:0] i_dividend,
    input  logic [SZW-1:0] i_divisor,
    output logic           o_done,
    output logic [SZW-1:0] o_rem
);

    localparam int CW = $clog2(DVW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [DVW-1:0] r_dvd;
    logic [SZW-1:0] r_div;
    logic [SZW-1:0] r_rem;
    logic [SZW:0]   w_trial;
    logic [SZW-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[DVW-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = SZW'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = w_trial[SZW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> tb/pitch_step_sequencer_core_test.sv
// Self-checking testbench for the pitch step sequencer core.
`timescale 1ns / 100ps

module pitch_step_sequencer_core_test;
    import pss_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int HOLD_CYCLES = 400;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [4:0] cfg_data = '0;

    pitch_step_sequencer_core #(
        .MAX_PITCHES(TABLE_DEPTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // sequencer state as the block should hold it
    logic [7:0]  tab_pitch [TABLE_DEPTH];
    logic [3:0]  pos_now = '0;
    logic [3:0]  pos_prev = '0;
    logic        dir_up = 1'b1;
    logic [31:0] lcg_state = LCG_SEED;
    logic [1:0]  order_reg = ORD_FORWARD;
    logic [4:0]  size_reg = '0;

    t_in_item  pending_steps [$];
    t_out_item pending_notes [$];
    t_out_item want_note;
    int queued_total = 0;
    int accepted_total = 0;
    int mismatch_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_req_cnt = 0;
    int hold_seen_cnt = 0;
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    bit beat_taken;

    function automatic t_out_item sequence_step(input t_in_item it);
        int span;
        t_out_item note;
        span = (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_reg);
        case (it.func)
            FN_ADVANCE: begin
                if (span == 1) begin
                    pos_prev = pos_now;
                    pos_now  = '0;
                end else if (span > 1) begin
                    pos_prev = pos_now;
                    case (order_reg)
                        ORD_FORWARD:  pos_now = 4'((int'(pos_now) + 1) % span);
                        ORD_BACKWARD: pos_now = 4'((int'(pos_now) + span - 1) % span);
                        ORD_PENDULUM: begin
                            // turn at either end; a shrunk size makes it walk back down
                            if (dir_up && int'(pos_now) >= span - 1)
                                dir_up = 1'b0;
                            else if (!dir_up && pos_now == 4'd0)
                                dir_up = 1'b1;
                            pos_now = dir_up ? pos_now + 4'd1 : pos_now - 4'd1;
                        end
                        default: begin
                            lcg_state = lcg_state * LCG_MUL + LCG_INC;
                            pos_now = 4'(int'(lcg_state[23:16]) % span);
                        end
                    endcase
                end
            end
            FN_SET_POS: begin
                if (span == 0) begin
                    pos_now  = '0;
                    pos_prev = '0;
                end else begin
                    pos_prev = pos_now;
                    pos_now  = 4'(int'(it.new_position) % span);
                end
            end
            FN_WRITE: begin
                tab_pitch[it.entry_index] = it.entry_pitch;
            end
            default: begin
                pos_now  = '0;
                pos_prev = '0;
                dir_up   = 1'b1;
            end
        endcase
        note.position = pos_now;
        if (span == 0) begin
            note.pitch          = '0;
            note.previous_pitch = '0;
        end else begin
            note.pitch          = tab_pitch[pos_now];
            note.previous_pitch = tab_pitch[pos_prev];
        end
        return note;
    endfunction

    // mostly short, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic t_in_item rand_beat(input logic [1:0] fn);
        t_in_item it;
        it.func         = fn;
        it.new_position = 8'($urandom_range(0, 255));
        it.entry_index  = 4'($urandom_range(0, 15));
        it.entry_pitch  = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic t_in_item random_beat();
        int r;
        t_in_item it;
        r = $urandom_range(0, 99);
        if (r < 60)
            it = rand_beat(FN_ADVANCE);
        else if (r < 75)
            it = rand_beat(FN_SET_POS);
        else if (r < 92)
            it = rand_beat(FN_WRITE);
        else
            it = rand_beat(FN_RESTART);
        r = $urandom_range(0, 9);
        if (r == 0)
            it.new_position = 8'hFF;
        else if (r == 1)
            it.new_position = 8'h00;
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
    endtask

    task automatic queue_beat(input t_in_item it);
        pending_steps.push_back(it);
        queued_total++;
    endtask

    task automatic cfg_write(input logic idx, input logic [4:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_PLAY_ORDER) begin
            order_reg = value[1:0];
            dir_up    = 1'b1;
        end else begin
            size_reg = value;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (accepted_total != queued_total || pending_notes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            beat_taken = in_valid && !in_stall;
            if (beat_taken) begin
                pending_notes.push_back(sequence_step(in_data));
                accepted_total++;
                gap_left = (tx_idle_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
            end
            if (beat_taken || !in_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_steps.size() != 0) begin
                    in_data  <= pending_steps.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result stall
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (hold_seen_cnt != hold_req_cnt) begin
                hold_seen_cnt = hold_req_cnt;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
                stall_left = idle_length() - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_notes.size() == 0) begin
                report_mismatch("result beat with none pending", 32'(out_data), 0);
            end else begin
                want_note = pending_notes.pop_front();
                if (out_data.pitch !== want_note.pitch)
                    report_mismatch("pitch", 32'(out_data.pitch), 32'(want_note.pitch));
                if (out_data.previous_pitch !== want_note.previous_pitch)
                    report_mismatch("previous_pitch", 32'(out_data.previous_pitch),
                                    32'(want_note.previous_pitch));
                if (out_data.position !== want_note.position)
                    report_mismatch("position", 32'(out_data.position),
                                    32'(want_note.position));
            end
        end
    end

    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int ph;
        int n;
        int hold_phase;
        logic [4:0] size_pick;
        logic [1:0] ord_pick;
        t_in_item beat;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty set: everything reads back as zero; fill the whole table here
        queue_beat(rand_beat(FN_ADVANCE));
        beat = rand_beat(FN_SET_POS);
        beat.new_position = 8'hFF;
        queue_beat(beat);
        queue_beat(rand_beat(FN_RESTART));
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            beat = rand_beat(FN_WRITE);
            beat.entry_index = 4'(i);
            beat.entry_pitch = (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : beat.entry_pitch;
            queue_beat(beat);
        end
        wait_drained();

        // random order, size above the table saturates
        cfg_write(CFG_PLAY_ORDER, {3'b111, ORD_RANDOM});
        cfg_write(CFG_SET_SIZE, 5'd31);
        queue_beat(rand_beat(FN_ADVANCE));
        queue_beat(rand_beat(FN_ADVANCE));
        beat = rand_beat(FN_SET_POS);
        beat.new_position = 8'hFF;
        queue_beat(beat);
        queue_beat(rand_beat(FN_ADVANCE));
        queue_beat(rand_beat(FN_RESTART));
        wait_drained();

        // single entry
        cfg_write(CFG_SET_SIZE, 5'd1);
        queue_beat(rand_beat(FN_ADVANCE));
        queue_beat(rand_beat(FN_SET_POS));
        wait_drained();

        hold_phase = $urandom_range(5, 29);
        for (ph = 0; ph < 30; ph++) begin
            wait_drained();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            ord_pick = (ph < 8) ? 2'(ph % 4) : 2'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       size_pick = 5'd0;
                1:       size_pick = 5'd1;
                2:       size_pick = 5'd2;
                3:       size_pick = 5'd16;
                4:       size_pick = 5'($urandom_range(17, 31));
                default: size_pick = 5'($urandom_range(2, 16));
            endcase
            if ($urandom_range(0, 1)) begin
                cfg_write(CFG_PLAY_ORDER, {3'($urandom_range(0, 7)), ord_pick});
                cfg_write(CFG_SET_SIZE, size_pick);
            end else begin
                cfg_write(CFG_SET_SIZE, size_pick);
                cfg_write(CFG_PLAY_ORDER, {3'($urandom_range(0, 7)), ord_pick});
            end
            // skipping the restart now and then leaves stale positions to recover from
            if ($urandom_range(0, 9) != 0)
                queue_beat(rand_beat(FN_RESTART));
            n = $urandom_range(30, 60);
            repeat (n) queue_beat(random_beat());
            if (ph == 2 || ph == hold_phase)
                hold_req_cnt++;
        end
        wait_drained();
        repeat (50) @(posedge clk);

        if (mismatch_count == 0 && pending_notes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
sv/pss_pkg.sv
sv/pss_ram.sv
sv/pss_mod.sv
sv/pitch_step_sequencer_core.sv
tb/pitch_step_sequencer_core_test.sv
